### rtl/m5v5t_pkg.sv
// ----------------------------------------------------------------------------
// m5v5t_pkg
// Shared constants and types of the homogeneous matrix-vector transform.
// ----------------------------------------------------------------------------
package m5v5t_pkg;

    localparam int DIM       = 5;
    localparam int FRAC_BITS = 16;

    localparam int WORD_W   = 32;
    localparam int NUM_COMP = 5;
    localparam int VEC_N    = (DIM > NUM_COMP) ? DIM : NUM_COMP;
    localparam int NUM_COEF = DIM * DIM;
    localparam int IDX_W    = 5;
    localparam int PROD_W   = 2 * WORD_W;
    localparam int HALF     = (DIM + 1) / 2;
    localparam int SUM_W    = PROD_W + $clog2(DIM) + 1;
    localparam int SH_W     = SUM_W - FRAC_BITS;

    localparam logic MODE_LOAD      = 1'b0;
    localparam logic MODE_TRANSFORM = 1'b1;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic signed [SH_W-1:0]   t_shift;

endpackage

### rtl/matrix5_vector5_transform_top.sv
// ----------------------------------------------------------------------------
// matrix5_vector5_transform_top
// Q16.16 matrix times homogeneous vector with saturated outputs.
// ----------------------------------------------------------------------------
// A load word (mode 0) writes one coefficient of the row-major matrix and gives
// no result; an index past the last coefficient is ignored. A transform word
// (mode 1) presents one result word: the five row dot products, each clipped
// to 32 bits, with a flag if any was clipped. One word is taken every cycle
// while o_stall is low; the result passes through the four register stages
// (products, half sums, row sum and shift, saturation). Each stage holds only
// while the stage after it is full and stalled, so bubbles are squeezed out.
// A load takes effect for every transform word taken after it. The matrix
// reads zero after reset.
module matrix5_vector5_transform_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_mode,
    input  logic [4:0]  i_coef_index,
    input  logic signed [31:0] i_coef_value,
    input  logic signed [31:0] i_in_x,
    input  logic signed [31:0] i_in_y,
    input  logic signed [31:0] i_in_z,
    input  logic signed [31:0] i_in_w,
    input  logic signed [31:0] i_in_v,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic signed [31:0] o_out_w,
    output logic signed [31:0] o_out_v,
    output logic        o_saturated
);

    m5v5t_pkg::t_word  r_mat [m5v5t_pkg::NUM_COEF];
    m5v5t_pkg::t_word  vec [m5v5t_pkg::VEC_N];

    logic              r_v1, r_v2, r_v3, r_v4;
    logic              en1, en2, en3, en4;
    logic              accept;

    m5v5t_pkg::t_prod  r_prod [m5v5t_pkg::DIM][m5v5t_pkg::DIM];
    m5v5t_pkg::t_prod  n_prod [m5v5t_pkg::DIM][m5v5t_pkg::DIM];
    m5v5t_pkg::t_sum   r_lo [m5v5t_pkg::DIM];
    m5v5t_pkg::t_sum   r_hi [m5v5t_pkg::DIM];
    m5v5t_pkg::t_sum   n_lo [m5v5t_pkg::DIM];
    m5v5t_pkg::t_sum   n_hi [m5v5t_pkg::DIM];
    m5v5t_pkg::t_sum   row_sum [m5v5t_pkg::DIM];
    m5v5t_pkg::t_shift r_sh [m5v5t_pkg::DIM];
    m5v5t_pkg::t_shift n_sh [m5v5t_pkg::DIM];
    m5v5t_pkg::t_word  r_out [m5v5t_pkg::NUM_COMP];
    m5v5t_pkg::t_word  n_out [m5v5t_pkg::NUM_COMP];
    logic              r_sat;
    logic              n_sat;

    // stage enables
    assign en4    = !r_v4 || !i_stall;
    assign en3    = !r_v3 || en4;
    assign en2    = !r_v2 || en3;
    assign en1    = !r_v1 || en2;
    assign o_stall = !en1;
    assign accept  = i_valid && en1;

    always_comb begin
        vec[0] = i_in_x;
        vec[1] = i_in_y;
        vec[2] = i_in_z;
        vec[3] = i_in_w;
        vec[4] = i_in_v;
        for (int j = m5v5t_pkg::NUM_COMP; j < m5v5t_pkg::VEC_N; j++) begin
            vec[j] = '0;
        end
    end

    // coefficient store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < m5v5t_pkg::NUM_COEF; k++) begin
                r_mat[k] <= '0;
            end
        end else if (accept && i_mode == m5v5t_pkg::MODE_LOAD) begin
            for (int k = 0; k < m5v5t_pkg::NUM_COEF; k++) begin
                if (i_coef_index == m5v5t_pkg::IDX_W'(k)) begin
                    r_mat[k] <= i_coef_value;
                end
            end
        end
    end

    // products
    always_comb begin
        for (int r = 0; r < m5v5t_pkg::DIM; r++) begin
            for (int j = 0; j < m5v5t_pkg::DIM; j++) begin
                n_prod[r][j] = r_mat[r*m5v5t_pkg::DIM + j] * vec[j];
            end
        end
    end

    // half row sums
    always_comb begin
        for (int r = 0; r < m5v5t_pkg::DIM; r++) begin
            n_lo[r] = '0;
            n_hi[r] = '0;
            for (int j = 0; j < m5v5t_pkg::DIM; j++) begin
                if (j < m5v5t_pkg::HALF) begin
                    n_lo[r] = n_lo[r] + m5v5t_pkg::SUM_W'(r_prod[r][j]);
                end else begin
                    n_hi[r] = n_hi[r] + m5v5t_pkg::SUM_W'(r_prod[r][j]);
                end
            end
        end
    end

    // row sum, arithmetic shift
    always_comb begin
        for (int r = 0; r < m5v5t_pkg::DIM; r++) begin
            row_sum[r] = r_lo[r] + r_hi[r];
            n_sh[r]    = $signed(row_sum[r][m5v5t_pkg::SUM_W-1:m5v5t_pkg::FRAC_BITS]);
        end
    end

    // saturation
    always_comb begin
        n_sat = 1'b0;
        for (int r = 0; r < m5v5t_pkg::NUM_COMP; r++) begin
            n_out[r] = '0;
        end
        for (int r = 0; r < m5v5t_pkg::DIM; r++) begin
            if (r < m5v5t_pkg::NUM_COMP) begin
                if (&r_sh[r][m5v5t_pkg::SH_W-1:m5v5t_pkg::WORD_W-1] ||
                    !(|r_sh[r][m5v5t_pkg::SH_W-1:m5v5t_pkg::WORD_W-1])) begin
                    n_out[r] = r_sh[r][m5v5t_pkg::WORD_W-1:0];
                end else begin
                    n_sat    = 1'b1;
                    n_out[r] = r_sh[r][m5v5t_pkg::SH_W-1]
                             ? {1'b1, {(m5v5t_pkg::WORD_W-1){1'b0}}}
                             : {1'b0, {(m5v5t_pkg::WORD_W-1){1'b1}}};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= accept && i_mode == m5v5t_pkg::MODE_TRANSFORM;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_prod <= n_prod;
        end
        if (en2) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
        if (en3) begin
            r_sh <= n_sh;
        end
        if (en4) begin
            r_out <= n_out;
            r_sat <= n_sat;
        end
    end

    assign o_valid     = r_v4;
    assign o_out_x     = r_out[0];
    assign o_out_y     = r_out[1];
    assign o_out_z     = r_out[2];
    assign o_out_w     = r_out[3];
    assign o_out_v     = r_out[4];
    assign o_saturated = r_sat;

`ifndef ASSERT_OFF
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_mode == m5v5t_pkg::MODE_LOAD) |=> !r_v1)
        else $error("load word entered the product stage");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !en2) |=> r_v2 && $stable(r_lo[0]))
        else $error("stalled half-sum stage lost its word");

    a_sat_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (o_out_x == 32'sh7FFFFFFF || o_out_x == 32'sh80000000 ||
             o_out_y == 32'sh7FFFFFFF || o_out_y == 32'sh80000000 ||
             o_out_z == 32'sh7FFFFFFF || o_out_z == 32'sh80000000 ||
             o_out_w == 32'sh7FFFFFFF || o_out_w == 32'sh80000000 ||
             o_out_v == 32'sh7FFFFFFF || o_out_v == 32'sh80000000))
        else $error("saturation flag without a clipped output");

    a_out_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !o_valid) |=> o_valid)
        else $error("row sum did not reach the empty output stage");
`endif

endmodule

### tb/tb_matrix5_vector5_transform_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_matrix5_vector5_transform_top
// Self-checking bench for the Q16.16 5x5 matrix times vector transform.
// Load words fill the coefficient store and transform words send points
// through it. Most values are random, and directed words hit the full-scale
// corners, the ignored indexes and the floor rounding. A scoreboard keeps its
// own copy of the matrix and predicts the saturated dot products of every
// accepted point. Both ports idle at random, and a watchdog catches a hang.
// ----------------------------------------------------------------------------
module tb_matrix5_vector5_transform_top;

    localparam int RANDOM_WORDS = 1560;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 12;

    typedef logic [m5v5t_pkg::NUM_COMP-1:0][m5v5t_pkg::WORD_W-1:0] t_point;

    typedef struct packed {
        logic [m5v5t_pkg::NUM_COMP-1:0][m5v5t_pkg::WORD_W-1:0] comp;
        logic                                                  sat;
    } t_xform_result;

    class xform_scoreboard;
        m5v5t_pkg::t_word coef [m5v5t_pkg::NUM_COEF];
        t_xform_result    expected_points [$];
        string            lane_name [m5v5t_pkg::NUM_COMP];
        int               errors;

        function new();
            foreach (coef[i]) coef[i] = '0;
            lane_name = '{"out_x", "out_y", "out_z", "out_w", "out_v"};
            errors    = 0;
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        // loads update the matrix copy, transforms queue the predicted point
        function void apply_word(logic mode, logic [m5v5t_pkg::IDX_W-1:0] idx,
                                 m5v5t_pkg::t_word value, t_point vec);
            logic signed [69:0] acc;
            logic signed [69:0] ea;
            logic signed [69:0] eb;
            logic signed [69:0] sh;
            t_xform_result      res;
            if (mode == m5v5t_pkg::MODE_LOAD) begin
                if (idx < m5v5t_pkg::NUM_COEF) coef[idx] = value;
                return;
            end
            res = '0;
            for (int r = 0; r < m5v5t_pkg::DIM; r++) begin
                acc = '0;
                for (int c = 0; c < m5v5t_pkg::DIM; c++) begin
                    ea  = coef[r*m5v5t_pkg::DIM+c];
                    eb  = $signed(vec[c]);
                    acc = acc + ea * eb;
                end
                sh = acc >>> m5v5t_pkg::FRAC_BITS;
                if (sh > 70'sd2147483647) begin
                    res.comp[r] = 32'h7fff_ffff;
                    res.sat     = 1'b1;
                end else if (sh < -70'sd2147483648) begin
                    res.comp[r] = 32'h8000_0000;
                    res.sat     = 1'b1;
                end else begin
                    res.comp[r] = sh[31:0];
                end
            end
            expected_points.push_back(res);
        endfunction

        task check_result(t_xform_result got);
            t_xform_result want;
            if (expected_points.size() == 0) begin
                report("result word with no transform pending");
                return;
            end
            want = expected_points.pop_front();
            for (int k = 0; k < m5v5t_pkg::NUM_COMP; k++) begin
                if (got.comp[k] !== want.comp[k])
                    report($sformatf("%s got %h want %h", lane_name[k],
                                     got.comp[k], want.comp[k]));
            end
            if (got.sat !== want.sat)
                report($sformatf("saturated got %b want %b", got.sat, want.sat));
        endtask

        function int pending();
            return expected_points.size();
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic              i_mode;
    logic [4:0]        i_coef_index;
    logic signed [31:0] i_coef_value;
    logic signed [31:0] i_in_x;
    logic signed [31:0] i_in_y;
    logic signed [31:0] i_in_z;
    logic signed [31:0] i_in_w;
    logic signed [31:0] i_in_v;
    logic              o_valid;
    logic              i_stall;
    logic signed [31:0] o_out_x;
    logic signed [31:0] o_out_y;
    logic signed [31:0] o_out_z;
    logic signed [31:0] o_out_w;
    logic signed [31:0] o_out_v;
    logic              o_saturated;

    xform_scoreboard sb;
    bit              calm;
    int              idle_cycles;

    matrix5_vector5_transform_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_mode       (i_mode),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .i_in_x       (i_in_x),
        .i_in_y       (i_in_y),
        .i_in_z       (i_in_z),
        .i_in_w       (i_in_w),
        .i_in_v       (i_in_v),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_out_z      (o_out_z),
        .o_out_w      (o_out_w),
        .o_out_v      (o_out_v),
        .o_saturated  (o_saturated)
    );

    always #2 i_clk = ~i_clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic m5v5t_pkg::t_word pick_value();
        m5v5t_pkg::t_word raw;
        int               r;
        raw = $urandom;
        r   = $urandom_range(99);
        if (r < 12) begin
            case ($urandom_range(4))
                0:       return 32'h8000_0000;
                1:       return 32'h7fff_ffff;
                2:       return 32'h0000_0000;
                3:       return 32'hffff_ffff;
                default: return 32'h0000_0001;
            endcase
        end
        if (r < 75) return raw >>> $urandom_range(28, 8);
        return raw;
    endfunction

    function automatic t_point mkvec(m5v5t_pkg::t_word x, m5v5t_pkg::t_word y,
                                     m5v5t_pkg::t_word z, m5v5t_pkg::t_word w,
                                     m5v5t_pkg::t_word v);
        return {v, w, z, y, x};
    endfunction

    function automatic t_point rand_vec();
        return mkvec(pick_value(), pick_value(), pick_value(), pick_value(), pick_value());
    endfunction

    task automatic send_word(logic mode, logic [m5v5t_pkg::IDX_W-1:0] idx,
                             m5v5t_pkg::t_word value, t_point vec);
        int gap;
        i_valid      <= 1'b1;
        i_mode       <= mode;
        i_coef_index <= idx;
        i_coef_value <= value;
        i_in_x       <= vec[0];
        i_in_y       <= vec[1];
        i_in_z       <= vec[2];
        i_in_w       <= vec[3];
        i_in_v       <= vec[4];
        do @(posedge i_clk); while (o_stall);
        sb.apply_word(mode, idx, value, vec);
        gap = calm ? 0 : gap_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic load_coef(logic [m5v5t_pkg::IDX_W-1:0] idx, m5v5t_pkg::t_word value);
        send_word(m5v5t_pkg::MODE_LOAD, idx, value, rand_vec());
    endtask

    task automatic transform(t_point vec);
        send_word(m5v5t_pkg::MODE_TRANSFORM, 5'($urandom), $urandom, vec);
    endtask

    // output side stall pattern
    initial begin
        int run;
        int hold;
        i_stall = 1'b0;
        forever begin
            run = $urandom_range(8, 1);
            i_stall <= 1'b0;
            repeat (run) @(posedge i_clk);
            hold = calm ? 0 : gap_len();
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_xform_result got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.comp[0] = o_out_x;
            got.comp[1] = o_out_y;
            got.comp[2] = o_out_z;
            got.comp[3] = o_out_w;
            got.comp[4] = o_out_v;
            got.sat     = o_saturated;
            sb.check_result(got);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        int useful;
        int r;
        sb           = new();
        calm         = 1'b0;
        idle_cycles  = 0;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_mode       = m5v5t_pkg::MODE_LOAD;
        i_coef_index = '0;
        i_coef_value = '0;
        i_in_x       = '0;
        i_in_y       = '0;
        i_in_z       = '0;
        i_in_w       = '0;
        i_in_v       = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // cleared matrix, extreme point
        transform(mkvec(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                        32'hffff_ffff));
        load_coef(5'd0, 32'h0001_0000);
        load_coef(5'd6, 32'hffff_0000);
        // indexes past the store are ignored
        load_coef(5'd31, 32'h7fff_ffff);
        load_coef(5'd25, 32'h8000_0000);
        // floor rounding of negative fractions
        transform(mkvec(32'hffff_ffff, 32'h0001_8000, 32'h0, 32'h0, 32'h0));
        load_coef(5'd12, 32'h8000_0000);
        load_coef(5'd18, 32'h7fff_ffff);
        load_coef(5'd24, 32'h0000_0001);
        transform(mkvec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000));
        transform(mkvec(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                        32'h7fff_ffff));
        transform(mkvec(32'h0, 32'h0, 32'h0, 32'h0, 32'h0000_0001));
        transform(mkvec(32'h0, 32'h0, 32'h0, 32'h0, 32'hffff_ffff));
        // full-scale row, exact sum wider than 64 bits
        for (int c = 0; c < m5v5t_pkg::DIM; c++) load_coef(5'(c), 32'h8000_0000);
        transform(mkvec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000));
        transform(mkvec(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                        32'h7fff_ffff));
        load_coef(5'd20, 32'h7fff_ffff);
        transform(mkvec(32'h0000_0001, 32'h0, 32'h0, 32'h0, 32'h8000_0000));

        useful = 0;
        while (useful < RANDOM_WORDS) begin
            if ($urandom_range(99) == 0) calm = !calm;
            r = $urandom_range(99);
            if (r < 5) begin
                load_coef(5'($urandom_range(31, m5v5t_pkg::NUM_COEF)), pick_value());
            end else if (r < 35) begin
                load_coef(5'($urandom_range(m5v5t_pkg::NUM_COEF-1)), pick_value());
                useful++;
            end else begin
                transform(rand_vec());
                useful++;
            end
        end
        i_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
